>>> design/x10hb_pkg.sv
// Package for the X-10 half-bit transmitter: item types, frame states and constants.
package x10hb_pkg;

	localparam int MSG_W      = 22;
	localparam int CNT_W      = 6;
	localparam int IDX_W      = 5;
	localparam int MSG_BITS_D = 22;
	localparam int PRE_ONES   = 3;
	localparam int SIL_HALVES = 6;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PRE  = 2'd1,
		PH_DATA = 2'd2,
		PH_SIL  = 2'd3
	} phase_t;

	typedef struct packed {
		logic             command;
		logic [MSG_W-1:0] message;
		logic             first_sample;
	} in_item_t;

	typedef struct packed {
		logic half_bit;
		logic busy_res;
		logic load_rejected;
		logic done_res;
	} out_item_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] half_count;
		logic [MSG_W-1:0] held_message;
	} frame_state_t;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

endpackage

>>> design/x10hb_chan_if.sv
// Valid/ready channel interface carrying one item per transfer.
interface x10hb_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/x10hb_step.sv
// Frame sequencer step: next state and result item for one accepted item.
module x10hb_step #(
	parameter int MSG_BITS = x10hb_pkg::MSG_BITS_D
) (
	input  x10hb_pkg::in_item_t     item,
	input  x10hb_pkg::frame_state_t cur,
	output x10hb_pkg::frame_state_t nxt,
	output x10hb_pkg::out_item_t    res
);
	localparam int MSG_W = x10hb_pkg::MSG_W;
	localparam int CNT_W = x10hb_pkg::CNT_W;
	localparam logic [MSG_W-1:0] KEPT_MASK = (MSG_BITS >= MSG_W) ? {MSG_W{1'b1}} :
		MSG_W'((32'd1 << MSG_BITS) - 32'd1);
	localparam logic [CNT_W-1:0] DATA_HALVES = CNT_W'(2 * MSG_BITS);
	localparam logic [CNT_W-1:0] PRE_CNT = CNT_W'(x10hb_pkg::PRE_ONES);
	localparam logic [CNT_W-1:0] SIL_CNT = CNT_W'(x10hb_pkg::SIL_HALVES);

	logic                       is_load;
	logic                       is_tick;
	logic                       held_nz;
	logic                       start;
	x10hb_pkg::phase_t          eff_phase;
	logic [CNT_W-1:0]           eff_cnt;
	logic [CNT_W-1:0]           cnt_dec;
	logic [x10hb_pkg::IDX_W-1:0] idx;
	logic                       data_bit;

	assign is_load   = (item.command == x10hb_pkg::CMD_LOAD);
	assign is_tick   = (item.command == x10hb_pkg::CMD_TICK) && item.first_sample;
	assign held_nz   = (cur.held_message != '0);
	assign start     = is_tick && (cur.phase == x10hb_pkg::PH_IDLE) && held_nz;
	assign eff_phase = start ? x10hb_pkg::PH_PRE : cur.phase;
	assign eff_cnt   = start ? PRE_CNT : cur.half_count;
	assign cnt_dec   = eff_cnt - CNT_W'(1);
	assign idx       = cnt_dec[CNT_W-1:1];
	assign data_bit  = (32'(idx) < MSG_W) ? cur.held_message[idx] : 1'b0;

	// next state
	always_comb begin
		nxt = cur;
		if (is_load) begin
			if (!held_nz) begin
				nxt.held_message = item.message & KEPT_MASK;
			end
		end else if (is_tick) begin
			nxt.phase      = eff_phase;
			nxt.half_count = eff_cnt;
			unique case (eff_phase)
				x10hb_pkg::PH_PRE: begin
					if (eff_cnt != '0) begin
						nxt.half_count = cnt_dec;
					end else begin
						nxt.phase      = x10hb_pkg::PH_DATA;
						nxt.half_count = DATA_HALVES;
					end
				end
				x10hb_pkg::PH_DATA: begin
					nxt.half_count = cnt_dec;
					if (cnt_dec == '0) begin
						nxt.phase      = x10hb_pkg::PH_SIL;
						nxt.half_count = SIL_CNT;
					end
				end
				x10hb_pkg::PH_SIL: begin
					nxt.half_count = cnt_dec;
					if (cnt_dec == '0) begin
						nxt.phase        = x10hb_pkg::PH_IDLE;
						nxt.held_message = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result item
	always_comb begin
		res               = '0;
		res.load_rejected = is_load && held_nz;
		if (is_tick) begin
			unique case (eff_phase)
				x10hb_pkg::PH_PRE:  res.half_bit = (eff_cnt != '0);
				x10hb_pkg::PH_DATA: res.half_bit = eff_cnt[0] ? ~data_bit : data_bit;
				x10hb_pkg::PH_SIL:  res.done_res = (cnt_dec == '0);
				default:            res.half_bit = 1'b0;
			endcase
		end
		res.busy_res = (nxt.held_message != '0) || (nxt.phase != x10hb_pkg::PH_IDLE);
	end

endmodule

>>> design/x10_half_bit_transmitter_core.sv
// X-10 half-bit transmitter top level: frame state, result register and handshakes.
// The result register fills in the cycle after an input transfer and frees when read out.
// Throughput: one item per cycle unless out_item stalls, which holds the input.
// Each item reads and updates the frame state in the cycle it is accepted.
// Reset clears the frame state to idle with nothing held and empties the result register.
module x10_half_bit_transmitter_core #(
	parameter int MSG_BITS = x10hb_pkg::MSG_BITS_D
) (
	input logic         clk,
	input logic         arst_n,
	x10hb_chan_if.sink   in_item,
	x10hb_chan_if.source out_item
);
	x10hb_pkg::frame_state_t state_q;
	x10hb_pkg::frame_state_t state_nxt;
	x10hb_pkg::out_item_t    res_nxt;
	x10hb_pkg::out_item_t    res_q;
	logic                    res_valid_q;
	logic                    accept;

	assign in_item.ready    = !res_valid_q || out_item.ready;
	assign accept           = in_item.valid && in_item.ready;
	assign out_item.valid   = res_valid_q;
	assign out_item.payload = res_q;

	x10hb_step #(
		.MSG_BITS(MSG_BITS)
	) u_step (
		.item(in_item.payload),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{phase: x10hb_pkg::PH_IDLE, half_count: '0, held_message: '0};
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				res_valid_q <= 1'b1;
			end else if (out_item.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	a_frame_holds_msg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != x10hb_pkg::PH_IDLE |-> state_q.held_message != '0)
		else $error("frame in progress with no message held");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res && state_q.held_message == '0)
		else $error("done reported while still busy");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.load_rejected |-> res_q.busy_res && !res_q.half_bit
			&& !res_q.done_res)
		else $error("rejected load with inconsistent result");

	a_state_only_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(state_q))
		else $error("frame state changed without a transfer");

endmodule

>>> tb/tb_top.sv
// Testbench for the X-10 half-bit transmitter core: directed tests, random frames and noise vs a frame encoder.
`timescale 1ns / 1ps

module tb_top;
	localparam int MSG_W = x10hb_pkg::MSG_W;
	localparam int CNT_W = x10hb_pkg::CNT_W;
	localparam int IDX_W = x10hb_pkg::IDX_W;
	localparam int N_BITS = x10hb_pkg::MSG_BITS_D;
	localparam logic [MSG_W-1:0] KEPT_MASK = MSG_W'((64'd1 << N_BITS) - 64'd1);
	localparam logic [CNT_W-1:0] DATA_HALVES = CNT_W'(2 * N_BITS);

	logic clk = 1'b0;
	logic arst_n;

	x10hb_chan_if #(.T(x10hb_pkg::in_item_t))  in_ch ();
	x10hb_chan_if #(.T(x10hb_pkg::out_item_t)) out_ch ();

	x10_half_bit_transmitter_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_ch.sink),
		.out_item (out_ch.source)
	);

	always #5 clk = ~clk;

	// frame encoder state
	x10hb_pkg::phase_t fr_phase;
	logic [CNT_W-1:0]  fr_count;
	logic [MSG_W-1:0]  fr_msg;

	x10hb_pkg::out_item_t tx_results_q[$];
	int                   err_count;
	int                   n_items;
	bit                   no_gaps;

	function automatic x10hb_pkg::out_item_t encode_half_bit(x10hb_pkg::in_item_t it);
		x10hb_pkg::out_item_t r;
		logic [CNT_W-1:0]     idx;
		logic                 b;
		r = '0;
		if (it.command == x10hb_pkg::CMD_LOAD) begin
			if (fr_msg != '0)
				r.load_rejected = 1'b1;
			else
				fr_msg = it.message & KEPT_MASK;
		end else if (it.first_sample) begin
			if (fr_phase == x10hb_pkg::PH_IDLE && fr_msg != '0) begin
				fr_phase = x10hb_pkg::PH_PRE;
				fr_count = CNT_W'(x10hb_pkg::PRE_ONES);
			end
			case (fr_phase)
				x10hb_pkg::PH_PRE: begin
					if (fr_count != '0) begin
						r.half_bit = 1'b1;
						fr_count = fr_count - CNT_W'(1);
					end else begin
						fr_phase = x10hb_pkg::PH_DATA;
						fr_count = DATA_HALVES;
					end
				end
				x10hb_pkg::PH_DATA: begin
					idx = (fr_count - CNT_W'(1)) >> 1;
					b = (idx < CNT_W'(MSG_W)) ? fr_msg[idx[IDX_W-1:0]] : 1'b0;
					r.half_bit = fr_count[0] ? ~b : b;
					fr_count = fr_count - CNT_W'(1);
					if (fr_count == '0) begin
						fr_phase = x10hb_pkg::PH_SIL;
						fr_count = CNT_W'(x10hb_pkg::SIL_HALVES);
					end
				end
				x10hb_pkg::PH_SIL: begin
					fr_count = fr_count - CNT_W'(1);
					if (fr_count == '0) begin
						fr_phase = x10hb_pkg::PH_IDLE;
						fr_msg = '0;
						r.done_res = 1'b1;
					end
				end
				default: ;
			endcase
		end
		r.busy_res = (fr_msg != '0) || (fr_phase != x10hb_pkg::PH_IDLE);
		return r;
	endfunction

	task automatic push_item(logic cmd, logic [MSG_W-1:0] msg, logic fs);
		x10hb_pkg::in_item_t it;
		int                  gap;
		it.command = cmd;
		it.message = msg;
		it.first_sample = fs;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		tx_results_q.push_back(encode_half_bit(it));
		n_items++;
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (tx_results_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic report_field(string name, logic want, logic got);
		$display("%0t mismatch %s: expected %0b actual %0b", $time, name, want, got);
		err_count++;
	endtask

	// result checker with random receive stalls
	initial begin
		int                   stall;
		x10hb_pkg::out_item_t got;
		x10hb_pkg::out_item_t want;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			got = out_ch.payload;
			if (tx_results_q.size() == 0) begin
				$display("%0t unexpected result: expected none actual %b", $time, got);
				err_count++;
			end else begin
				want = tx_results_q.pop_front();
				if (got.half_bit !== want.half_bit)
					report_field("half_bit", want.half_bit, got.half_bit);
				if (got.busy_res !== want.busy_res)
					report_field("busy_res", want.busy_res, got.busy_res);
				if (got.load_rejected !== want.load_rejected)
					report_field("load_rejected", want.load_rejected, got.load_rejected);
				if (got.done_res !== want.done_res)
					report_field("done_res", want.done_res, got.done_res);
			end
		end
	end

	task automatic test_idle_ticks();
		push_item(x10hb_pkg::CMD_TICK, 22'h3FFFFF, 1'b1);
		push_item(x10hb_pkg::CMD_TICK, 22'h000000, 1'b0);
		push_item(x10hb_pkg::CMD_LOAD, 22'h000000, 1'b0);
		push_item(x10hb_pkg::CMD_TICK, 22'h155555, 1'b1);
	endtask

	task automatic test_load_reject();
		push_item(x10hb_pkg::CMD_LOAD, 22'h3FFFFF, 1'b1);
		push_item(x10hb_pkg::CMD_LOAD, 22'h155555, 1'b0);
		push_item(x10hb_pkg::CMD_TICK, 22'h2AAAAA, 1'b0);
		repeat (4) push_item(x10hb_pkg::CMD_TICK, 22'h000000, 1'b1);
		push_item(x10hb_pkg::CMD_LOAD, 22'h000001, 1'b1);
		repeat (3) push_item(x10hb_pkg::CMD_TICK, 22'h3FFFFF, 1'b1);
		push_item(x10hb_pkg::CMD_TICK, 22'h3FFFFF, 1'b0);
	endtask

	function automatic logic [MSG_W-1:0] pick_message();
		case ($urandom_range(0, 7))
			0: return 22'h000001;
			1: return 22'h200000;
			2: return 22'h3FFFFF;
			3: return 22'h2AAAAA;
			default: return MSG_W'($urandom_range(1, 22'h3FFFFF));
		endcase
	endfunction

	// load a message and tick until the frame finishes, with noise mixed in
	task automatic run_frame();
		int sel;
		if (fr_msg == '0 && fr_phase == x10hb_pkg::PH_IDLE)
			push_item(x10hb_pkg::CMD_LOAD, pick_message(), 1'($urandom_range(0, 1)));
		while (fr_msg != '0 || fr_phase != x10hb_pkg::PH_IDLE) begin
			sel = $urandom_range(0, 99);
			if (sel < 85)
				push_item(x10hb_pkg::CMD_TICK, MSG_W'($urandom), 1'b1);
			else if (sel < 93)
				push_item(x10hb_pkg::CMD_TICK, MSG_W'($urandom), 1'b0);
			else
				push_item(x10hb_pkg::CMD_LOAD, MSG_W'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_frames();
		int n_frames;
		n_frames = 0;
		while (n_items < 1050) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			run_frame();
			n_frames++;
			if (n_frames % 5 == 0)
				drain_results();
		end
		no_gaps = 1'b0;
		drain_results();
	endtask

	task automatic test_noise();
		logic [MSG_W-1:0] msg;
		repeat (250) begin
			msg = ($urandom_range(0, 9) == 0) ? '0 : MSG_W'($urandom);
			push_item(1'($urandom_range(0, 1)), msg, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int guard;
		err_count = 0;
		n_items = 0;
		no_gaps = 1'b0;
		fr_phase = x10hb_pkg::PH_IDLE;
		fr_count = '0;
		fr_msg = '0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.payload <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_load_reject();
		test_frames();
		test_noise();

		in_ch.valid <= 1'b0;
		guard = 0;
		while (tx_results_q.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		if (tx_results_q.size() != 0) begin
			$display("%0t results missing: expected %0d more actual 0", $time,
				tx_results_q.size());
			err_count++;
		end
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("[x10_half_bit_transmitter_core] OK");
		else
			$display("[x10_half_bit_transmitter_core] ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("[x10_half_bit_transmitter_core] ERROR");
		$finish;
	end

endmodule

>>> x10_half_bit_transmitter_core.f
design/x10hb_pkg.sv
design/x10hb_chan_if.sv
design/x10hb_step.sv
design/x10_half_bit_transmitter_core.sv
tb/tb_top.sv
